@@ rtl/core/sc2a_pkg.sv @@
// shared types, codes and lookup functions for the set 1 scan code decoder
// no dependencies
package sc2a_pkg;

	localparam int unsigned ByteW = 8;
	localparam int unsigned CodeW = 7;
	localparam int unsigned CharW = 7;

	localparam logic [CodeW-1:0] KEY_LSHIFT  = 7'd42;
	localparam logic [CodeW-1:0] KEY_RSHIFT  = 7'd54;
	localparam logic [CharW-1:0] CHAR_NONE   = 7'h00;
	localparam logic [CharW-1:0] CHAR_LOW_A  = 7'h61;
	localparam logic [CharW-1:0] CHAR_LOW_Z  = 7'h7a;
	localparam logic [CharW-1:0] CASE_OFFSET = 7'h20;

	typedef struct packed {
		logic             char_valid;
		logic [CharW-1:0] char_code;
		logic             shift_held;
	} result_t;

	// us layout, unshifted
	function automatic logic [CharW-1:0] us_map(input logic [CodeW-1:0] code);
		logic [CharW-1:0] c;
		case (code)
			7'd1:    c = 7'h1b;
			7'd2:    c = 7'h31;
			7'd3:    c = 7'h32;
			7'd4:    c = 7'h33;
			7'd5:    c = 7'h34;
			7'd6:    c = 7'h35;
			7'd7:    c = 7'h36;
			7'd8:    c = 7'h37;
			7'd9:    c = 7'h38;
			7'd10:   c = 7'h39;
			7'd11:   c = 7'h30;
			7'd12:   c = 7'h2d;
			7'd13:   c = 7'h3d;
			7'd14:   c = 7'h08;
			7'd15:   c = 7'h09;
			7'd16:   c = 7'h71;
			7'd17:   c = 7'h77;
			7'd18:   c = 7'h65;
			7'd19:   c = 7'h72;
			7'd20:   c = 7'h74;
			7'd21:   c = 7'h79;
			7'd22:   c = 7'h75;
			7'd23:   c = 7'h69;
			7'd24:   c = 7'h6f;
			7'd25:   c = 7'h70;
			7'd26:   c = 7'h5b;
			7'd27:   c = 7'h5d;
			7'd28:   c = 7'h0a;
			7'd30:   c = 7'h61;
			7'd31:   c = 7'h73;
			7'd32:   c = 7'h64;
			7'd33:   c = 7'h66;
			7'd34:   c = 7'h67;
			7'd35:   c = 7'h68;
			7'd36:   c = 7'h6a;
			7'd37:   c = 7'h6b;
			7'd38:   c = 7'h6c;
			7'd39:   c = 7'h3b;
			7'd40:   c = 7'h27;
			7'd41:   c = 7'h60;
			7'd43:   c = 7'h5c;
			7'd44:   c = 7'h7a;
			7'd45:   c = 7'h78;
			7'd46:   c = 7'h63;
			7'd47:   c = 7'h76;
			7'd48:   c = 7'h62;
			7'd49:   c = 7'h6e;
			7'd50:   c = 7'h6d;
			7'd51:   c = 7'h2c;
			7'd52:   c = 7'h2e;
			7'd53:   c = 7'h2f;
			7'd55:   c = 7'h2a;
			7'd57:   c = 7'h20;
			7'd74:   c = 7'h2d;
			7'd78:   c = 7'h2b;
			default: c = CHAR_NONE;
		endcase
		return c;
	endfunction

	// shifted symbol or upper case
	function automatic logic [CharW-1:0] shifted_form(input logic [CharW-1:0] c);
		logic [CharW-1:0] s;
		case (c)
			7'h60:   s = 7'h7e;
			7'h31:   s = 7'h21;
			7'h32:   s = 7'h40;
			7'h33:   s = 7'h23;
			7'h34:   s = 7'h24;
			7'h35:   s = 7'h25;
			7'h36:   s = 7'h5e;
			7'h37:   s = 7'h26;
			7'h38:   s = 7'h2a;
			7'h39:   s = 7'h28;
			7'h30:   s = 7'h29;
			7'h2d:   s = 7'h5f;
			7'h3d:   s = 7'h2b;
			7'h5b:   s = 7'h7b;
			7'h5d:   s = 7'h7d;
			7'h5c:   s = 7'h7c;
			7'h3b:   s = 7'h3a;
			7'h27:   s = 7'h22;
			7'h2c:   s = 7'h3c;
			7'h2e:   s = 7'h3e;
			7'h2f:   s = 7'h3f;
			default: begin
				if (c inside {[CHAR_LOW_A:CHAR_LOW_Z]}) begin
					s = c - CASE_OFFSET;
				end else begin
					s = c;
				end
			end
		endcase
		return s;
	endfunction

endpackage

@@ rtl/core/sc2a_in_reg.sv @@
// input register stage holding one raw scan byte
// uses sc2a_pkg
module sc2a_in_reg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        scan_valid,
	output logic                        scan_ready,
	input  logic [sc2a_pkg::ByteW-1:0]  scan_byte,
	output logic                        valid_s1,
	output logic [sc2a_pkg::ByteW-1:0]  byte_s1,
	input  logic                        advance
);

	assign scan_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (scan_ready) begin
			valid_s1 <= scan_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (scan_valid && scan_ready) begin
			byte_s1 <= scan_byte;
		end
	end

endmodule

@@ rtl/core/sc2a_decode.sv @@
// table lookup, shift handling and the shift flag register
// uses sc2a_pkg
module sc2a_decode (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [sc2a_pkg::ByteW-1:0]  byte_s1,
	input  logic                        advance,
	output sc2a_pkg::result_t           result
);

	logic                        shift_q;
	logic                        shift_next;
	logic                        release_bit;
	logic                        is_shift;
	logic [sc2a_pkg::CodeW-1:0]  code;
	logic [sc2a_pkg::CharW-1:0]  base_char;
	logic [sc2a_pkg::CharW-1:0]  out_char;

	assign code        = byte_s1[sc2a_pkg::CodeW-1:0];
	assign release_bit = byte_s1[sc2a_pkg::ByteW-1];
	assign is_shift    = (code == sc2a_pkg::KEY_LSHIFT) || (code == sc2a_pkg::KEY_RSHIFT);
	assign shift_next  = is_shift ? !release_bit : shift_q;

	always_comb begin
		base_char = release_bit ? sc2a_pkg::CHAR_NONE : sc2a_pkg::us_map(code);
		if (base_char != sc2a_pkg::CHAR_NONE && shift_next) begin
			out_char = sc2a_pkg::shifted_form(base_char);
		end else begin
			out_char = base_char;
		end
		result.char_valid = (out_char != sc2a_pkg::CHAR_NONE);
		result.char_code  = out_char;
		result.shift_held = shift_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q <= 1'b0;
		end else if (advance) begin
			shift_q <= shift_next;
		end
	end

endmodule

@@ rtl/core/sc2a_out_reg.sv @@
// result register feeding the output channel
// uses sc2a_pkg
module sc2a_out_reg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        valid_s1,
	output logic                        advance,
	input  sc2a_pkg::result_t           result,
	output logic                        result_valid,
	input  logic                        result_ready,
	output logic                        char_valid,
	output logic [sc2a_pkg::CharW-1:0]  char_code,
	output logic                        shift_held
);

	logic              valid_s2;
	sc2a_pkg::result_t result_s2;

	assign advance = valid_s1 && (!valid_s2 || result_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || result_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result;
		end
	end

	assign result_valid = valid_s2;
	assign char_valid   = result_s2.char_valid;
	assign char_code    = result_s2.char_code;
	assign shift_held   = result_s2.shift_held;

endmodule

@@ rtl/core/scancode_set1_to_ascii.sv @@
// set 1 scan code to ascii decoder
// throughput one request per cycle while result_ready is held, one result per request
// input register, table lookup with shift logic, result register
// arst_n clears both stage valids and the shift flag (shift released)
// uses sc2a_pkg, sc2a_in_reg, sc2a_decode, sc2a_out_reg
module scancode_set1_to_ascii (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        scan_valid,
	output logic                        scan_ready,
	input  logic [sc2a_pkg::ByteW-1:0]  scan_byte,
	output logic                        result_valid,
	input  logic                        result_ready,
	output logic                        char_valid,
	output logic [sc2a_pkg::CharW-1:0]  char_code,
	output logic                        shift_held
);

	logic                        valid_s1;
	logic [sc2a_pkg::ByteW-1:0]  byte_s1;
	logic                        advance;
	sc2a_pkg::result_t           result;

	sc2a_in_reg u_in_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.scan_valid (scan_valid),
		.scan_ready (scan_ready),
		.scan_byte  (scan_byte),
		.valid_s1   (valid_s1),
		.byte_s1    (byte_s1),
		.advance    (advance)
	);

	sc2a_decode u_decode (
		.clk     (clk),
		.arst_n  (arst_n),
		.byte_s1 (byte_s1),
		.advance (advance),
		.result  (result)
	);

	sc2a_out_reg u_out_reg (
		.clk          (clk),
		.arst_n       (arst_n),
		.valid_s1     (valid_s1),
		.advance      (advance),
		.result       (result),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.char_valid   (char_valid),
		.char_code    (char_code),
		.shift_held   (shift_held)
	);

endmodule

@@ rtl/core/sc2a_checker.sv @@
// port-level assertions for the scan code decoder, bound to the top level
// uses sc2a_pkg
module sc2a_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        scan_valid,
	input logic                        scan_ready,
	input logic [sc2a_pkg::ByteW-1:0]  scan_byte,
	input logic                        result_valid,
	input logic                        result_ready,
	input logic                        char_valid,
	input logic [sc2a_pkg::CharW-1:0]  char_code,
	input logic                        shift_held
);

	a_valid_code: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && char_valid |-> char_code != sc2a_pkg::CHAR_NONE)
		else $error("char_valid with null code");

	a_idle_code: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !char_valid |-> char_code == sc2a_pkg::CHAR_NONE)
		else $error("nonzero code without char_valid");

	a_upper_case: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && char_valid && shift_held
		|-> !(char_code >= sc2a_pkg::CHAR_LOW_A && char_code <= sc2a_pkg::CHAR_LOW_Z))
		else $error("lower case letter under shift");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready
		|=> result_valid && $stable(char_valid) && $stable(char_code) && $stable(shift_held))
		else $error("stalled result changed");

	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		scan_valid && !scan_ready |=> scan_valid && $stable(scan_byte))
		else $error("stalled request changed");

endmodule

bind scancode_set1_to_ascii sc2a_checker u_sc2a_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.scan_valid   (scan_valid),
	.scan_ready   (scan_ready),
	.scan_byte    (scan_byte),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.char_valid   (char_valid),
	.char_code    (char_code),
	.shift_held   (shift_held)
);

@@ tb/tb_scancode_set1_to_ascii.sv @@
`timescale 1ns / 100ps
// self-checking testbench for scancode_set1_to_ascii: directed table then random requests,
// each result checked against its table row or a local decoder with its own shift flag
// depends on sc2a_pkg and scancode_set1_to_ascii
module tb_scancode_set1_to_ascii;
	import sc2a_pkg::*;

	localparam logic [ByteW-1:0] RELEASE_BIT = 8'h80;
	localparam int unsigned RANDOM_REQUESTS = 400;
	localparam int unsigned CYCLE_LIMIT = 40000;
	localparam int unsigned DRAIN_CYCLES = 10;

	typedef struct {
		logic [ByteW-1:0] code_byte;
		bit               typed;
		logic             want_valid;
		logic [CharW-1:0] want_char;
		logic             want_shift;
	} stim_row_t;

	localparam int unsigned NUM_ROWS = 24;
	stim_row_t stim_rows [NUM_ROWS] = '{
		'{8'h00, 1'b1, 1'b0, 7'h00, 1'b0},
		'{8'h01, 1'b1, 1'b1, 7'h1b, 1'b0},
		'{8'h10, 1'b1, 1'b1, 7'h71, 1'b0},
		'{8'h2b, 1'b1, 1'b1, 7'h5c, 1'b0},
		'{8'h7f, 1'b1, 1'b0, 7'h00, 1'b0},
		'{8'h5a, 1'b1, 1'b0, 7'h00, 1'b0},
		'{8'hff, 1'b1, 1'b0, 7'h00, 1'b0},
		'{8'h80, 1'b1, 1'b0, 7'h00, 1'b0},
		'{8'h2a, 1'b1, 1'b0, 7'h00, 1'b1},
		'{8'h10, 1'b0, 1'b0, 7'h00, 1'b0},
		'{8'h29, 1'b0, 1'b0, 7'h00, 1'b0},
		'{8'h4a, 1'b1, 1'b1, 7'h5f, 1'b1},
		'{8'h39, 1'b1, 1'b1, 7'h20, 1'b1},
		'{8'h37, 1'b1, 1'b1, 7'h2a, 1'b1},
		'{8'h4e, 1'b1, 1'b1, 7'h2b, 1'b1},
		'{8'h0e, 1'b1, 1'b1, 7'h08, 1'b1},
		'{8'h3b, 1'b1, 1'b0, 7'h00, 1'b1},
		'{8'h2a, 1'b1, 1'b0, 7'h00, 1'b1},
		'{8'haa, 1'b1, 1'b0, 7'h00, 1'b0},
		'{8'h36, 1'b1, 1'b0, 7'h00, 1'b1},
		'{8'h02, 1'b0, 1'b0, 7'h00, 1'b0},
		'{8'h35, 1'b0, 1'b0, 7'h00, 1'b0},
		'{8'hb6, 1'b1, 1'b0, 7'h00, 1'b0},
		'{8'h1c, 1'b1, 1'b1, 7'h0a, 1'b0}
	};

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             scan_valid = 1'b0;
	logic             scan_ready;
	logic [ByteW-1:0] scan_byte = '0;
	logic             result_valid;
	logic             result_ready = 1'b0;
	logic             char_valid;
	logic [CharW-1:0] char_code;
	logic             shift_held;

	result_t     pending_chars [$];
	logic        shift_down = 1'b0;
	int unsigned fail_count = 0;
	int unsigned cycle_count = 0;
	int unsigned sent_count = 0;

	scancode_set1_to_ascii u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.scan_valid   (scan_valid),
		.scan_ready   (scan_ready),
		.scan_byte    (scan_byte),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.char_valid   (char_valid),
		.char_code    (char_code),
		.shift_held   (shift_held)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// us layout, no modifiers
	function automatic logic [CharW-1:0] plain_ascii(input logic [CodeW-1:0] make);
		logic [CharW-1:0] a;
		case (make)
			7'd1:  a = 7'h1b;  7'd2:  a = 7'h31;  7'd3:  a = 7'h32;  7'd4:  a = 7'h33;
			7'd5:  a = 7'h34;  7'd6:  a = 7'h35;  7'd7:  a = 7'h36;  7'd8:  a = 7'h37;
			7'd9:  a = 7'h38;  7'd10: a = 7'h39;  7'd11: a = 7'h30;  7'd12: a = 7'h2d;
			7'd13: a = 7'h3d;  7'd14: a = 7'h08;  7'd15: a = 7'h09;  7'd16: a = 7'h71;
			7'd17: a = 7'h77;  7'd18: a = 7'h65;  7'd19: a = 7'h72;  7'd20: a = 7'h74;
			7'd21: a = 7'h79;  7'd22: a = 7'h75;  7'd23: a = 7'h69;  7'd24: a = 7'h6f;
			7'd25: a = 7'h70;  7'd26: a = 7'h5b;  7'd27: a = 7'h5d;  7'd28: a = 7'h0a;
			7'd30: a = 7'h61;  7'd31: a = 7'h73;  7'd32: a = 7'h64;  7'd33: a = 7'h66;
			7'd34: a = 7'h67;  7'd35: a = 7'h68;  7'd36: a = 7'h6a;  7'd37: a = 7'h6b;
			7'd38: a = 7'h6c;  7'd39: a = 7'h3b;  7'd40: a = 7'h27;  7'd41: a = 7'h60;
			7'd43: a = 7'h5c;  7'd44: a = 7'h7a;  7'd45: a = 7'h78;  7'd46: a = 7'h63;
			7'd47: a = 7'h76;  7'd48: a = 7'h62;  7'd49: a = 7'h6e;  7'd50: a = 7'h6d;
			7'd51: a = 7'h2c;  7'd52: a = 7'h2e;  7'd53: a = 7'h2f;  7'd55: a = 7'h2a;
			7'd57: a = 7'h20;  7'd74: a = 7'h2d;  7'd78: a = 7'h2b;
			default: a = CHAR_NONE;
		endcase
		return a;
	endfunction

	function automatic logic [CharW-1:0] upper_ascii(input logic [CharW-1:0] a);
		logic [CharW-1:0] u;
		case (a)
			7'h60: u = 7'h7e;  7'h31: u = 7'h21;  7'h32: u = 7'h40;  7'h33: u = 7'h23;
			7'h34: u = 7'h24;  7'h35: u = 7'h25;  7'h36: u = 7'h5e;  7'h37: u = 7'h26;
			7'h38: u = 7'h2a;  7'h39: u = 7'h28;  7'h30: u = 7'h29;  7'h2d: u = 7'h5f;
			7'h3d: u = 7'h2b;  7'h5b: u = 7'h7b;  7'h5d: u = 7'h7d;  7'h5c: u = 7'h7c;
			7'h3b: u = 7'h3a;  7'h27: u = 7'h22;  7'h2c: u = 7'h3c;  7'h2e: u = 7'h3e;
			7'h2f: u = 7'h3f;
			default: begin
				if (a >= 7'h61 && a <= 7'h7a) begin
					u = a - 7'h20;
				end else begin
					u = a;
				end
			end
		endcase
		return u;
	endfunction

	// advances the local shift flag
	function automatic result_t decode_key_byte(input logic [ByteW-1:0] b);
		result_t          r;
		logic [CodeW-1:0] make;
		logic             is_shift;
		logic [CharW-1:0] a;
		make = b[CodeW-1:0];
		is_shift = (make == KEY_LSHIFT) || (make == KEY_RSHIFT);
		a = CHAR_NONE;
		if ((b & RELEASE_BIT) != 0) begin
			if (is_shift) begin
				shift_down = 1'b0;
			end
		end else begin
			if (is_shift) begin
				shift_down = 1'b1;
			end
			a = plain_ascii(make);
			if (a != CHAR_NONE && shift_down) begin
				a = upper_ascii(a);
			end
		end
		r.char_valid = (a != CHAR_NONE);
		r.char_code = a;
		r.shift_held = shift_down;
		return r;
	endfunction

	function automatic logic [ByteW-1:0] random_key_byte();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 12) begin
			return {1'b0, ($urandom_range(0, 1) != 0) ? KEY_LSHIFT : KEY_RSHIFT};
		end else if (pick < 24) begin
			return RELEASE_BIT | {1'b0, ($urandom_range(0, 1) != 0) ? KEY_LSHIFT : KEY_RSHIFT};
		end else if (pick < 70) begin
			return ByteW'($urandom_range(1, 57));
		end else if (pick < 85) begin
			return ByteW'($urandom_range(0, 127));
		end
		return ByteW'($urandom_range(0, 255));
	endfunction

	task automatic send_key_byte(input logic [ByteW-1:0] b, input bit typed, input result_t want);
		result_t model;
		bit      calm;
		calm = (sent_count >= 250 && sent_count < 330);
		while (!calm && $urandom_range(0, 99) < 19) begin
			scan_valid <= 1'b0;
			@(posedge clk);
		end
		scan_valid <= 1'b1;
		scan_byte <= b;
		@(posedge clk);
		while (!scan_ready) begin
			@(posedge clk);
		end
		model = decode_key_byte(b);
		pending_chars.push_back(typed ? want : model);
		sent_count++;
	endtask

	// receiver: random stalls, one long hold-off, one stretch always ready
	initial begin
		int unsigned n;
		n = 0;
		forever begin
			@(posedge clk);
			n++;
			if (n >= 300 && n < 380) begin
				result_ready <= 1'b0;
			end else if (n >= 450 && n < 600) begin
				result_ready <= 1'b1;
			end else begin
				result_ready <= ($urandom_range(0, 99) >= 19);
			end
		end
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_valid && result_ready) begin
			if (pending_chars.size() == 0) begin
				$error("result with no request outstanding");
				fail_count++;
			end else begin
				want = pending_chars.pop_front();
				if (char_valid !== want.char_valid) begin
					$error("char_valid: expected %0b, got %0b", want.char_valid, char_valid);
					fail_count++;
				end
				if (char_code !== want.char_code) begin
					$error("char_code: expected %h, got %h", want.char_code, char_code);
					fail_count++;
				end
				if (shift_held !== want.shift_held) begin
					$error("shift_held: expected %0b, got %0b", want.shift_held, shift_held);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		result_t want;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (stim_rows[i]) begin
			want.char_valid = stim_rows[i].want_valid;
			want.char_code = stim_rows[i].want_char;
			want.shift_held = stim_rows[i].want_shift;
			send_key_byte(stim_rows[i].code_byte, stim_rows[i].typed, want);
		end
		want = '0;
		repeat (RANDOM_REQUESTS) begin
			send_key_byte(random_key_byte(), 1'b0, want);
		end
		scan_valid <= 1'b0;
		while (pending_chars.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
